// ===== sv/pgsa_pkg.sv =====
// Shared types and constants for the polar grid scatter-average block.
// Used by pgsa_div and polar_grid_scatter_average; depends on nothing.
package pgsa_pkg;

   // Field and storage widths
   localparam int SUM_W     = 48;
   localparam int HITS_W    = 16;
   localparam int VALUE_W   = 32;
   localparam int AVG_W     = 32;
   localparam int COORD_W   = 6;
   localparam int GRID_W    = 7;
   localparam int ENTRY_W   = SUM_W + HITS_W;
   localparam int DIV_CNT_W = $clog2(SUM_W);

   localparam logic [GRID_W-1:0]       GRID_RESET = 7'd64;
   localparam logic signed [SUM_W-1:0] SUM_MAX    = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN    = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic [HITS_W-1:0]       HITS_MAX   = '1;
   localparam logic [AVG_W-1:0]        AVG_POS_MAX = {1'b0, {(AVG_W-1){1'b1}}};
   localparam logic [AVG_W-1:0]        AVG_NEG_MAX = {1'b1, {(AVG_W-1){1'b0}}};

   // Status codes
   localparam logic STATUS_DONE    = 1'b0;
   localparam logic STATUS_IGNORED = 1'b1;

   // Request kinds carried in tuser
   typedef enum logic [1:0] {
      ACT_ACCUM = 2'd0,
      ACT_READ  = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   // Main controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACC,
      ST_RDWAIT,
      ST_DIV,
      ST_OUT
   } state_type;

   // Divider states
   typedef enum logic [1:0] {
      DV_IDLE,
      DV_RUN,
      DV_ROUND,
      DV_DONE
   } div_state_type;

   // Divider request and response
   typedef struct packed {
      logic                    start;
      logic signed [SUM_W-1:0] sum;
      logic [HITS_W-1:0]       hits;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [AVG_W-1:0] average;
   } div_rsp_type;

   // One result transaction
   typedef struct packed {
      logic [AVG_W-1:0]  average;
      logic [HITS_W-1:0] hits;
      logic              status;
   } result_type;

endpackage

// ===== sv/pgsa_mem.sv =====
// Cell storage of the scatter-average block: one write port, one read port,
// read data registered. Depends on nothing.
module pgsa_mem #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12,
   parameter int W     = 64
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [W-1:0]  wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [W-1:0]  rd_data
);

   logic [W-1:0] mem_ff [DEPTH];
   logic [W-1:0] rd_data_ff;

   // Write the entry, register the read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/pgsa_div.sv =====
// Bit-serial divider that turns a cell sum and hit count into a rounded,
// saturated Q16.16 average. Depends on pgsa_pkg.
module pgsa_div (
   input  logic                 clock,
   input  logic                 reset,
   input  pgsa_pkg::div_req_type req,
   output pgsa_pkg::div_rsp_type rsp
);

   localparam logic [pgsa_pkg::DIV_CNT_W-1:0] LAST_STEP =
      pgsa_pkg::DIV_CNT_W'(pgsa_pkg::SUM_W - 1);

   pgsa_pkg::div_state_type dv_state_ff, dv_state_in;
   logic [pgsa_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [pgsa_pkg::SUM_W-1:0]     quo_ff, quo_in;
   logic [pgsa_pkg::HITS_W-1:0]    rem_ff, rem_in;
   logic [pgsa_pkg::HITS_W-1:0]    hits_ff, hits_in;
   logic                           neg_ff, neg_in;
   logic [pgsa_pkg::SUM_W:0]       qr_ff, qr_in;

   logic [pgsa_pkg::HITS_W:0]   shifted;
   logic [pgsa_pkg::HITS_W+1:0] diff;
   logic                        ge;
   logic                        round_up;

   // One restoring step
   always_comb begin
      shifted  = {rem_ff, quo_ff[pgsa_pkg::SUM_W-1]};
      diff     = {1'b0, shifted} - {2'b00, hits_ff};
      ge       = !diff[pgsa_pkg::HITS_W+1];
      round_up = ({rem_ff, 1'b0} >= {1'b0, hits_ff});
   end

   // Next state
   always_comb begin
      dv_state_in = dv_state_ff;
      unique case (dv_state_ff)
         pgsa_pkg::DV_IDLE:  if (req.start) dv_state_in = pgsa_pkg::DV_RUN;
         pgsa_pkg::DV_RUN:   if (cnt_ff == LAST_STEP) dv_state_in = pgsa_pkg::DV_ROUND;
         pgsa_pkg::DV_ROUND: dv_state_in = pgsa_pkg::DV_DONE;
         pgsa_pkg::DV_DONE:  dv_state_in = pgsa_pkg::DV_IDLE;
         default:            dv_state_in = pgsa_pkg::DV_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      cnt_in      = cnt_ff;
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      hits_in     = hits_ff;
      neg_in      = neg_ff;
      qr_in       = qr_ff;
      rsp.done    = 1'b0;
      rsp.average = '0;
      unique case (dv_state_ff)
         pgsa_pkg::DV_IDLE: begin
            if (req.start) begin
               neg_in  = req.sum[pgsa_pkg::SUM_W-1];
               quo_in  = req.sum[pgsa_pkg::SUM_W-1] ? -req.sum : req.sum;
               rem_in  = '0;
               hits_in = req.hits;
               cnt_in  = '0;
            end
         end
         pgsa_pkg::DV_RUN: begin
            rem_in = ge ? diff[pgsa_pkg::HITS_W-1:0] : shifted[pgsa_pkg::HITS_W-1:0];
            quo_in = {quo_ff[pgsa_pkg::SUM_W-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
         end
         pgsa_pkg::DV_ROUND: begin
            qr_in = {1'b0, quo_ff} + (pgsa_pkg::SUM_W+1)'(round_up);
         end
         pgsa_pkg::DV_DONE: begin
            rsp.done = 1'b1;
            if (neg_ff) begin
               if (qr_ff >= (pgsa_pkg::SUM_W+1)'(pgsa_pkg::AVG_NEG_MAX)) begin
                  rsp.average = pgsa_pkg::AVG_NEG_MAX;
               end else begin
                  rsp.average = -qr_ff[pgsa_pkg::AVG_W-1:0];
               end
            end else begin
               if (qr_ff > (pgsa_pkg::SUM_W+1)'(pgsa_pkg::AVG_POS_MAX)) begin
                  rsp.average = pgsa_pkg::AVG_POS_MAX;
               end else begin
                  rsp.average = qr_ff[pgsa_pkg::AVG_W-1:0];
               end
            end
         end
         default: begin
            rsp.done = 1'b0;
         end
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_state_ff <= pgsa_pkg::DV_IDLE;
      end else begin
         dv_state_ff <= dv_state_in;
      end
      cnt_ff  <= cnt_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      hits_ff <= hits_in;
      neg_ff  <= neg_in;
      qr_ff   <= qr_in;
   end

endmodule

// ===== sv/polar_grid_scatter_average.sv =====
// Polar grid scatter-average: accumulates Q16.16 samples into the cells of a
// square grid and returns per-cell averages. An accumulate does one memory
// read and one write back. A read goes through the bit-serial divider, which
// works one quotient bit per cycle over the 48-bit sum; a read of a cell with
// no hits skips the divider. A clear sweeps all MAX_GRID*MAX_GRID cells one
// per cycle; the same sweep runs after reset, during which no request is
// taken (grid_size writes still are). An operation also stalls while the
// consumer holds off an earlier result that still waits.
// One result register sits on the response side, so the next request is taken
// while a result still waits.
// Depends on pgsa_pkg, pgsa_mem and pgsa_div.
module polar_grid_scatter_average #(
   parameter int MAX_GRID = 64
) (
   input  logic        clock,
   input  logic        reset,
   // Configuration
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data,   // grid_size
   // Request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,     // row[5:0], col[11:6], value[43:12], zero pad
   input  logic [1:0]  req_tuser,     // action[1:0]
   // Response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,     // average[31:0], hit_count[47:32]
   output logic        rsp_tuser      // status[0]
);

   localparam int CELLS = MAX_GRID * MAX_GRID;
   localparam int AW    = $clog2(CELLS);
   localparam logic [AW-1:0] LAST_ADDR  = AW'(CELLS - 1);
   localparam logic [8:0]    MAX_GRID_W = 9'(MAX_GRID);

   pgsa_pkg::state_type state_ff, state_in;
   logic [pgsa_pkg::GRID_W-1:0]  grid_ff;
   logic [AW-1:0]                clr_cnt_ff, clr_cnt_in;
   logic                         clr_rsp_ff, clr_rsp_in;
   logic [AW-1:0]                addr_ff, addr_in;
   logic [pgsa_pkg::VALUE_W-1:0] value_ff, value_in;
   pgsa_pkg::result_type         res_ff, res_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   pgsa_pkg::result_type         rsp_res_ff;

   // Request fields
   pgsa_pkg::action_type          req_action;
   logic [pgsa_pkg::COORD_W-1:0]  req_row, req_col;
   logic [pgsa_pkg::VALUE_W-1:0]  req_value;
   logic                          req_oor;
   logic [AW-1:0]                 req_addr;
   logic                          req_accept;

   // Memory port
   logic                          mem_wr_en, mem_rd_en;
   logic [AW-1:0]                 mem_wr_addr;
   logic [pgsa_pkg::ENTRY_W-1:0]  mem_wr_data, mem_rd_data;
   logic signed [pgsa_pkg::SUM_W-1:0] rd_sum;
   logic [pgsa_pkg::HITS_W-1:0]   rd_hits;

   // Accumulate arithmetic
   logic signed [pgsa_pkg::SUM_W:0]   acc_wide;
   logic signed [pgsa_pkg::SUM_W-1:0] acc_sum;
   logic [pgsa_pkg::HITS_W-1:0]       acc_hits;

   // Output register control
   logic                 out_free, out_load;
   pgsa_pkg::result_type out_res;

   pgsa_pkg::div_req_type div_req;
   pgsa_pkg::div_rsp_type div_rsp;

   // Unpack the request and check the coordinate against the grid in use
   always_comb begin
      req_action = pgsa_pkg::action_type'(req_tuser);
      req_row    = req_tdata[5:0];
      req_col    = req_tdata[11:6];
      req_value  = req_tdata[43:12];
      req_oor    = ({3'b000, req_row} >= {2'b00, grid_ff}) ||
                   ({3'b000, req_row} >= MAX_GRID_W) ||
                   ({3'b000, req_col} >= {2'b00, grid_ff}) ||
                   ({3'b000, req_col} >= MAX_GRID_W);
      req_addr   = AW'(32'(req_row) * MAX_GRID + 32'(req_col));
      req_accept = req_tvalid && req_tready;
   end

   // Saturating update of the stored cell
   always_comb begin
      rd_sum   = mem_rd_data[pgsa_pkg::SUM_W-1:0];
      rd_hits  = mem_rd_data[pgsa_pkg::ENTRY_W-1:pgsa_pkg::SUM_W];
      acc_wide = {rd_sum[pgsa_pkg::SUM_W-1], rd_sum} +
                 {{(pgsa_pkg::SUM_W+1-pgsa_pkg::VALUE_W){value_ff[pgsa_pkg::VALUE_W-1]}},
                  value_ff};
      if (acc_wide[pgsa_pkg::SUM_W] != acc_wide[pgsa_pkg::SUM_W-1]) begin
         acc_sum = acc_wide[pgsa_pkg::SUM_W] ? pgsa_pkg::SUM_MIN : pgsa_pkg::SUM_MAX;
      end else begin
         acc_sum = acc_wide[pgsa_pkg::SUM_W-1:0];
      end
      acc_hits = (rd_hits == pgsa_pkg::HITS_MAX) ? rd_hits : rd_hits + 1'b1;
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pgsa_pkg::ST_CLEAR: begin
            if (clr_cnt_ff == LAST_ADDR) begin
               state_in = clr_rsp_ff ? pgsa_pkg::ST_OUT : pgsa_pkg::ST_IDLE;
            end
         end
         pgsa_pkg::ST_IDLE: begin
            if (req_accept) begin
               unique case (req_action)
                  pgsa_pkg::ACT_CLEAR: state_in = pgsa_pkg::ST_CLEAR;
                  pgsa_pkg::ACT_ACCUM: state_in = req_oor ? pgsa_pkg::ST_OUT
                                                          : pgsa_pkg::ST_ACC;
                  pgsa_pkg::ACT_READ:  state_in = req_oor ? pgsa_pkg::ST_OUT
                                                          : pgsa_pkg::ST_RDWAIT;
                  default:             state_in = pgsa_pkg::ST_OUT;
               endcase
            end
         end
         pgsa_pkg::ST_ACC: begin
            state_in = out_free ? pgsa_pkg::ST_IDLE : pgsa_pkg::ST_OUT;
         end
         pgsa_pkg::ST_RDWAIT: begin
            state_in = (rd_hits == '0) ? pgsa_pkg::ST_OUT : pgsa_pkg::ST_DIV;
         end
         pgsa_pkg::ST_DIV: begin
            if (div_rsp.done) state_in = pgsa_pkg::ST_OUT;
         end
         pgsa_pkg::ST_OUT: begin
            if (out_free) state_in = pgsa_pkg::ST_IDLE;
         end
         default: state_in = pgsa_pkg::ST_IDLE;
      endcase
   end

   // State outputs: memory, divider and result control
   always_comb begin
      req_tready    = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = addr_ff;
      mem_wr_data   = '0;
      mem_rd_en     = 1'b0;
      clr_cnt_in    = clr_cnt_ff;
      clr_rsp_in    = clr_rsp_ff;
      addr_in       = addr_ff;
      value_in      = value_ff;
      res_in        = res_ff;
      div_req.start = 1'b0;
      div_req.sum   = rd_sum;
      div_req.hits  = rd_hits;
      out_load      = 1'b0;
      out_res       = res_ff;
      unique case (state_ff)
         pgsa_pkg::ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_cnt_ff;
            clr_cnt_in  = clr_cnt_ff + 1'b1;
         end
         pgsa_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_accept) begin
               addr_in    = req_addr;
               value_in   = req_value;
               res_in     = '0;
               clr_cnt_in = '0;
               clr_rsp_in = 1'b1;
               unique case (req_action) inside
                  pgsa_pkg::ACT_ACCUM, pgsa_pkg::ACT_READ: begin
                     mem_rd_en     = !req_oor;
                     res_in.status = req_oor ? pgsa_pkg::STATUS_IGNORED
                                             : pgsa_pkg::STATUS_DONE;
                  end
                  default: begin
                     res_in.status = pgsa_pkg::STATUS_DONE;
                  end
               endcase
            end
         end
         pgsa_pkg::ST_ACC: begin
            mem_wr_en      = 1'b1;
            mem_wr_data    = {acc_hits, acc_sum};
            res_in.average = '0;
            res_in.hits    = acc_hits;
            res_in.status  = pgsa_pkg::STATUS_DONE;
            out_load       = out_free;
            out_res        = res_in;
         end
         pgsa_pkg::ST_RDWAIT: begin
            res_in.average = '0;
            res_in.hits    = rd_hits;
            div_req.start  = (rd_hits != '0);
         end
         pgsa_pkg::ST_DIV: begin
            if (div_rsp.done) res_in.average = div_rsp.average;
         end
         pgsa_pkg::ST_OUT: begin
            out_load = out_free;
         end
         default: begin
            out_load = 1'b0;
         end
      endcase
   end

   // Hold the result until the consumer takes it
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pgsa_pkg::ST_CLEAR;
         grid_ff      <= pgsa_pkg::GRID_RESET;
         clr_cnt_ff   <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) grid_ff <= csr_wr_data;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      value_ff <= value_in;
      res_ff   <= res_in;
      if (out_load) rsp_res_ff <= out_res;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_res_ff.hits, rsp_res_ff.average};
   assign rsp_tuser  = rsp_res_ff.status;

   pgsa_mem #(
      .DEPTH (CELLS),
      .AW    (AW),
      .W     (pgsa_pkg::ENTRY_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (req_addr),
      .rd_data (mem_rd_data)
   );

   pgsa_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

`ifndef NO_ASSERTIONS
   // An in-range accumulate writes its cell back on the next cycle
   a_acc_writes: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_action == pgsa_pkg::ACT_ACCUM && !req_oor) |=> mem_wr_en)
      else $error("accumulate did not write back its cell");

   // A waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !out_load)
      else $error("pending result overwritten");

   // The divider finishes only while the controller waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == pgsa_pkg::ST_DIV))
      else $error("divider finished outside of a read");

   // A read that starts the divider came from a read request the cycle before
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> $past(req_accept && req_action == pgsa_pkg::ACT_READ))
      else $error("divider started without a read request");
`endif

endmodule

// ===== dv/polar_grid_scatter_average_tb.sv =====
// Self-checking testbench for polar_grid_scatter_average: directed table, then random
// phases over several grid sizes, checked by a cell model.
// Depends on pgsa_pkg and the polar_grid_scatter_average RTL.
`timescale 1ns / 100ps

module polar_grid_scatter_average_tb;

   localparam int MAX_GRID    = 64;
   localparam int CELLS       = MAX_GRID * MAX_GRID;
   localparam int STALL_LIMIT = 20000;
   localparam int N_DIRECTED  = 24;
   localparam int N_PHASES    = 8;

   // Action code with no function in the block
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      bit                   csr_set;
      logic [6:0]           csr_val;
      logic [1:0]           act;
      logic [5:0]           r;
      logic [5:0]           c;
      logic [31:0]          v;
      bit                   fixed_set;
      pgsa_pkg::result_type res;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [6:0]  csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic        rsp_tuser;

   // Cell model
   logic signed [pgsa_pkg::SUM_W-1:0] model_sum [CELLS];
   logic [pgsa_pkg::HITS_W-1:0]       model_hits [CELLS];
   logic [pgsa_pkg::GRID_W-1:0]       grid_size_model;

   pgsa_pkg::result_type cell_results_due [$];
   stim_row_type         directed_rows [N_DIRECTED];
   bit                   idling_on = 1'b1;
   int                   mismatches = 0;
   int                   idle_cycles = 0;

   always #6 clock = ~clock;

   polar_grid_scatter_average #(
      .MAX_GRID(MAX_GRID)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Rounded mean of a cell, ties away from zero, saturated to Q16.16 range
   function automatic logic [pgsa_pkg::AVG_W-1:0] rounded_mean(
      input logic signed [pgsa_pkg::SUM_W-1:0] sum,
      input logic [pgsa_pkg::HITS_W-1:0]       hits);
      logic [63:0] mag;
      logic [63:0] q;
      logic [63:0] r;
      logic        neg;
      if (hits == 0) return '0;
      neg = sum[pgsa_pkg::SUM_W-1];
      mag = neg ? 64'(-longint'(sum)) : 64'(longint'(sum));
      q = mag / {48'd0, hits};
      r = mag % {48'd0, hits};
      if (2 * r >= {48'd0, hits}) q = q + 1;
      if (neg) return (q >= 64'h8000_0000) ? pgsa_pkg::AVG_NEG_MAX : (~q[31:0] + 32'd1);
      return (q > 64'h7FFF_FFFF) ? pgsa_pkg::AVG_POS_MAX : q[31:0];
   endfunction

   // Apply one transaction to the cell model and return the result it should produce
   function automatic pgsa_pkg::result_type grid_predict(input logic [1:0] act,
                                                         input logic [5:0] r,
                                                         input logic [5:0] c,
                                                         input logic [31:0] v);
      pgsa_pkg::result_type res;
      int                   eff;
      int                   idx;
      longint               s;
      res        = '0;
      res.status = pgsa_pkg::STATUS_DONE;
      eff = (grid_size_model > MAX_GRID) ? MAX_GRID : int'(grid_size_model);
      if (act == pgsa_pkg::ACT_CLEAR) begin
         for (int i = 0; i < CELLS; i++) begin
            model_sum[i]  = '0;
            model_hits[i] = '0;
         end
         return res;
      end
      if (act == ACT_UNUSED) return res;
      if (r >= eff || c >= eff) begin
         res.status = pgsa_pkg::STATUS_IGNORED;
         return res;
      end
      idx = int'(r) * MAX_GRID + int'(c);
      if (act == pgsa_pkg::ACT_ACCUM) begin
         s = longint'(model_sum[idx]) + longint'($signed(v));
         if (s > longint'(pgsa_pkg::SUM_MAX)) s = longint'(pgsa_pkg::SUM_MAX);
         if (s < longint'(pgsa_pkg::SUM_MIN)) s = longint'(pgsa_pkg::SUM_MIN);
         model_sum[idx] = s[pgsa_pkg::SUM_W-1:0];
         if (model_hits[idx] != pgsa_pkg::HITS_MAX) model_hits[idx] = model_hits[idx] + 1'b1;
         res.hits = model_hits[idx];
         return res;
      end
      res.average = rounded_mean(model_sum[idx], model_hits[idx]);
      res.hits    = model_hits[idx];
      return res;
   endfunction

   function automatic logic [5:0] pick_coord(input int eff);
      int sel;
      sel = $urandom_range(0, 9);
      if (eff == 0 || sel == 9) return 6'($urandom_range(0, 63));
      if (sel < 5) return 6'($urandom_range(0, ((eff < 4) ? eff : 4) - 1));
      if (sel == 5) return 6'(eff - 1);
      if (sel == 6 && eff < MAX_GRID) return 6'(eff);
      return 6'($urandom_range(0, eff - 1));
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t mismatch %s: expected %h got %h", $realtime, what, want, got);
   endtask

   // Drive one request transaction, then record what it should return
   task automatic send_item(input logic [1:0] act, input logic [5:0] r, input logic [5:0] c,
                            input logic [31:0] v, input bit fixed_set,
                            input pgsa_pkg::result_type fixed_res);
      int                   gap;
      pgsa_pkg::result_type predicted;
      gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, v, c, r};
      req_tuser  <= act;
      do @(posedge clock); while (req_tready !== 1'b1);
      predicted = grid_predict(act, r, c, v);
      cell_results_due = {cell_results_due, (fixed_set ? fixed_res : predicted)};
   endtask

   task automatic send_random_item();
      int          eff;
      int          pick;
      logic [1:0]  act;
      logic [5:0]  r;
      logic [5:0]  c;
      logic [31:0] v;
      eff  = (grid_size_model > MAX_GRID) ? MAX_GRID : int'(grid_size_model);
      pick = $urandom_range(0, 99);
      if (pick == 0)      act = pgsa_pkg::ACT_CLEAR;
      else if (pick < 4)  act = ACT_UNUSED;
      else if (pick < 72) act = pgsa_pkg::ACT_ACCUM;
      else                act = pgsa_pkg::ACT_READ;
      r = pick_coord(eff);
      c = pick_coord(eff);
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 3))
               0: v = 32'h7FFF_FFFF;
               1: v = 32'h8000_0000;
               2: v = 32'h0000_0000;
               default: v = 32'hFFFF_FFFF;
            endcase
         end
         1, 2: v = $urandom;
         default: begin
            v = $urandom;
            v = 32'($signed(v) >>> $urandom_range(8, 30));
         end
      endcase
      send_item(act, r, c, v, 1'b0, '0);
   endtask

   // Hold off requests until every outstanding result has come back
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (cell_results_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_grid_size(input logic [6:0] gs);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= gs;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      grid_size_model = gs;
   endtask

   // Response side: stall in random bursts while idling is on
   initial begin
      rsp_tready = 1'b1;
      forever begin
         @(negedge clock);
         if (idling_on && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Compare each result transaction with the oldest expectation
   always @(posedge clock) begin : check_results
      pgsa_pkg::result_type got;
      pgsa_pkg::result_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         got.average = rsp_tdata[31:0];
         got.hits    = rsp_tdata[47:32];
         got.status  = rsp_tuser;
         if (cell_results_due.size() == 0) begin
            flag_mismatch("unexpected result, average", '0, got.average);
         end else begin
            want = cell_results_due.pop_front();
            if (got.average !== want.average)
               flag_mismatch("average", want.average, got.average);
            if (got.hits !== want.hits)
               flag_mismatch("hit_count", 32'(want.hits), 32'(got.hits));
            if (got.status !== want.status)
               flag_mismatch("status", 32'(want.status), 32'(got.status));
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   initial begin
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      int           phase_grid [N_PHASES];
      int           phase_items [N_PHASES];
      stim_row_type row;
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      grid_size_model = pgsa_pkg::GRID_RESET;
      for (int i = 0; i < CELLS; i++) begin
         model_sum[i]  = '0;
         model_hits[i] = '0;
      end

      // Directed rows; fixed expectations where the answer is obvious
      directed_rows = '{
         '{1'b0, 7'd0,   pgsa_pkg::ACT_READ,  6'd0,  6'd0,  32'h0000_0000, 1'b1,
           '{32'h0000_0000, 16'd0, pgsa_pkg::STATUS_DONE}},
         '{1'b0, 7'd0,   pgsa_pkg::ACT_ACCUM, 6'd63, 6'd63, 32'h7FFF_FFFF, 1'b1,
           '{32'h0000_0000, 16'd1, pgsa_pkg::STATUS_DONE}},
         '{1'b0, 7'd0,   pgsa_pkg::ACT_READ,  6'd63, 6'd63, 32'h0000_0000, 1'b1,
           '{32'h7FFF_FFFF, 16'd1, pgsa_pkg::STATUS_DONE}},
         '{1'b0, 7'd0,   pgsa_pkg::ACT_ACCUM, 6'd0,  6'd0,  32'h8000_0000, 1'b1,
           '{32'h0000_0000, 16'd1, pgsa_pkg::STATUS_DONE}},
         '{1'b0, 7'd0,   pgsa_pkg::ACT_READ,  6'd0,  6'd0,  32'h0000_0000, 1'b1,
           '{32'h8000_0000, 16'd1, pgsa_pkg::STATUS_DONE}},
         '{1'b0, 7'd0,   pgsa_pkg::ACT_ACCUM, 6'd5,  6'd9,  32'h0000_0001, 1'b0, '0},
         '{1'b0, 7'd0,   pgsa_pkg::ACT_ACCUM, 6'd5,  6'd9,  32'h0000_0002, 1'b0, '0},
         // half step rounds up
         '{1'b0, 7'd0,   pgsa_pkg::ACT_READ,  6'd5,  6'd9,  32'h0000_0000, 1'b1,
           '{32'h0000_0002, 16'd2, pgsa_pkg::STATUS_DONE}},
         '{1'b0, 7'd0,   pgsa_pkg::ACT_ACCUM, 6'd9,  6'd5,  32'hFFFF_FFFF, 1'b0, '0},
         '{1'b0, 7'd0,   pgsa_pkg::ACT_ACCUM, 6'd9,  6'd5,  32'hFFFF_FFFE, 1'b0, '0},
         // negative half step rounds away from zero
         '{1'b0, 7'd0,   pgsa_pkg::ACT_READ,  6'd9,  6'd5,  32'h0000_0000, 1'b1,
           '{32'hFFFF_FFFE, 16'd2, pgsa_pkg::STATUS_DONE}},
         '{1'b0, 7'd0,   ACT_UNUSED,          6'd63, 6'd63, 32'hA5A5_A5A5, 1'b1,
           '{32'h0000_0000, 16'd0, pgsa_pkg::STATUS_DONE}},
         '{1'b0, 7'd0,   pgsa_pkg::ACT_CLEAR, 6'd0,  6'd0,  32'h0000_0000, 1'b1,
           '{32'h0000_0000, 16'd0, pgsa_pkg::STATUS_DONE}},
         '{1'b0, 7'd0,   pgsa_pkg::ACT_READ,  6'd63, 6'd63, 32'h0000_0000, 1'b1,
           '{32'h0000_0000, 16'd0, pgsa_pkg::STATUS_DONE}},
         '{1'b0, 7'd0,   pgsa_pkg::ACT_ACCUM, 6'd1,  6'd2,  32'h0001_8000, 1'b0, '0},
         // one-cell grid: everything but cell 0,0 is out of range
         '{1'b1, 7'd1,   pgsa_pkg::ACT_ACCUM, 6'd0,  6'd1,  32'h0000_1234, 1'b1,
           '{32'h0000_0000, 16'd0, pgsa_pkg::STATUS_IGNORED}},
         '{1'b0, 7'd0,   pgsa_pkg::ACT_READ,  6'd1,  6'd0,  32'h0000_0000, 1'b1,
           '{32'h0000_0000, 16'd0, pgsa_pkg::STATUS_IGNORED}},
         '{1'b0, 7'd0,   pgsa_pkg::ACT_ACCUM, 6'd0,  6'd0,  32'h0001_0000, 1'b0, '0},
         '{1'b0, 7'd0,   pgsa_pkg::ACT_READ,  6'd0,  6'd0,  32'h0000_0000, 1'b0, '0},
         // zero-size grid rejects every cell
         '{1'b1, 7'd0,   pgsa_pkg::ACT_READ,  6'd0,  6'd0,  32'h0000_0000, 1'b1,
           '{32'h0000_0000, 16'd0, pgsa_pkg::STATUS_IGNORED}},
         '{1'b0, 7'd0,   pgsa_pkg::ACT_ACCUM, 6'd0,  6'd0,  32'h0000_0001, 1'b1,
           '{32'h0000_0000, 16'd0, pgsa_pkg::STATUS_IGNORED}},
         // oversize setting is limited to the full grid
         '{1'b1, 7'd127, pgsa_pkg::ACT_ACCUM, 6'd63, 6'd62, 32'h8000_0000, 1'b0, '0},
         '{1'b0, 7'd0,   pgsa_pkg::ACT_READ,  6'd63, 6'd62, 32'h0000_0000, 1'b0, '0},
         '{1'b1, 7'd64,  pgsa_pkg::ACT_READ,  6'd1,  6'd2,  32'h0000_0000, 1'b0, '0}
      };
      phase_grid  = '{5, 1, 127, 0, 33, 2, 64, 64};
      phase_items = '{260, 200, 260, 60, 260, 200, 330, 330};

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table
      for (int i = 0; i < N_DIRECTED; i++) begin
         row = directed_rows[i];
         if (row.csr_set) begin
            drain_results();
            write_grid_size(row.csr_val);
         end
         send_item(row.act, row.r, row.c, row.v, row.fixed_set, row.res);
      end

      // Random phases, one grid size each; the last one runs without idling
      for (int p = 0; p < N_PHASES; p++) begin
         drain_results();
         write_grid_size(7'(phase_grid[p]));
         for (int n = 0; n < phase_items[p]; n++) begin
            if (p == N_PHASES - 1)
               idling_on = 1'b0;
            else if (n % 40 == 0)
               idling_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 149) == 0) drain_results();
            send_random_item();
         end
      end

      drain_results();
      repeat (100) @(posedge clock);
      if (mismatches == 0 && cell_results_due.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
